// ===== rtl/pqsi_pkg.sv =====
package pqsi_pkg;

    // Default number of cells in the row.
    localparam int DefaultQueueDepth = 16;

    localparam int ValueWidth     = 32;
    localparam int PriorityWidth  = 8;
    localparam int OccupancyWidth = 5;
    localparam int StatusWidth    = 2;

    // Command codes carried in s_tuser.
    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

    // Status codes carried in m_tuser.
    localparam logic [StatusWidth-1:0] ST_ENQUEUED = 2'd0;
    localparam logic [StatusWidth-1:0] ST_DEQUEUED = 2'd1;
    localparam logic [StatusWidth-1:0] ST_EMPTY    = 2'd2;
    localparam logic [StatusWidth-1:0] ST_FULL     = 2'd3;

    // One queue entry as held in a cell.
    typedef struct packed {
        logic [PriorityWidth-1:0] prio;
        logic signed [ValueWidth-1:0] value;
    } entry_t;

    // Broadcast control shared by every cell of the row.
    typedef struct packed {
        logic   enq;
        logic   deq;
        entry_t new_entry;
    } cell_ctrl_t;

endpackage

// ===== rtl/pqsi_cell.sv =====
module pqsi_cell (
    input  logic                 aclk,
    input  pqsi_pkg::cell_ctrl_t ctrl,
    input  logic                 cell_valid,
    input  logic                 left_ge,
    input  pqsi_pkg::entry_t     left_entry,
    input  pqsi_pkg::entry_t     right_entry,
    output logic                 ge,
    output pqsi_pkg::entry_t     entry
);
    import pqsi_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // This cell stays ahead of a new entry when it holds an equal or higher priority.
    assign ge = cell_valid && (entry_reg.prio >= ctrl.new_entry.prio);

    // Keep, take the new entry, or take a neighbor's entry.
    always_comb begin
        entry_next = entry_reg;
        if (ctrl.enq) begin
            if (!ge) begin
                if (left_ge) begin
                    entry_next = ctrl.new_entry;
                end else begin
                    entry_next = left_entry;
                end
            end
        end else if (ctrl.deq) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/priority_queue_sorted_insert_top.sv =====
// Sorted priority queue built as a row of cells, front entry in cell zero.
// Input channel: s_tuser carries the command (enqueue or dequeue), s_tdata
// carries the value and priority. Every accepted item yields exactly one
// result transfer on the m_ channel: m_tuser carries the status, m_tdata the
// dequeued value and priority (zero otherwise) and the occupancy afterward.
// Higher priorities leave first; equal priorities leave in arrival order.
// An enqueue into a full queue is dropped and reported as full; a dequeue
// from an empty queue is reported as empty.
// Latency: the result is presented in the cycle after the input transfer.
// Throughput: one item per cycle. Every cell compares against the new item
// in parallel and keeps its entry or moves it one place in the same cycle, so
// the row update is a single step regardless of depth.
// The result sits in an output register; while the receiver stalls with a
// result pending, s_tready is low and nothing new is accepted. When the
// pending result is taken, a new item can be accepted in that same cycle.
// Reset (aresetn low, synchronous) empties the queue and drops any pending
// result; cell contents are not cleared and are never read before written.
module priority_queue_sorted_insert_top #(
    parameter int QUEUE_DEPTH = pqsi_pkg::DefaultQueueDepth
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // item_value [31:0], item_priority [39:32]
    input  logic [0:0]  s_tuser,  // command [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,  // out_value [31:0], out_priority [39:32],
                                  // occupancy [44:40], zero fill [47:45]
    output logic [1:0]  m_tuser   // status [1:0]
);
    import pqsi_pkg::*;

    localparam int CountWidth = $clog2(QUEUE_DEPTH + 1);

    logic [CountWidth-1:0] count_reg;
    logic [CountWidth-1:0] count_next;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [StatusWidth-1:0]       status_reg;
    logic [StatusWidth-1:0]       status_next;
    entry_t                       out_entry_reg;
    entry_t                       out_entry_next;
    logic [OccupancyWidth-1:0]    occ_reg;
    logic [OccupancyWidth-1:0]    occ_next;

    logic       in_fire;
    logic       is_full;
    logic       is_empty;
    cell_ctrl_t ctrl;

    entry_t                 cell_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_ge;

    // Accept a new item whenever the output register is free or being drained.
    assign s_tready = !out_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;
    assign is_full  = (count_reg == CountWidth'(QUEUE_DEPTH));
    assign is_empty = (count_reg == '0);

    // Broadcast control to the cell row.
    always_comb begin
        ctrl.enq             = in_fire && (s_tuser[0] == CMD_ENQUEUE) && !is_full;
        ctrl.deq             = in_fire && (s_tuser[0] == CMD_DEQUEUE) && !is_empty;
        ctrl.new_entry.value = s_tdata[31:0];
        ctrl.new_entry.prio  = s_tdata[39:32];
    end

    // Row of cells; cell zero sees an always-ahead left neighbor.
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic   left_ge_w;
        entry_t left_w;
        entry_t right_w;

        if (i == 0) begin : g_first
            assign left_ge_w = 1'b1;
            assign left_w    = ctrl.new_entry;
        end else begin : g_mid
            assign left_ge_w = cell_ge[i-1];
            assign left_w    = cell_entry[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_last
            assign right_w = cell_entry[i];
        end else begin : g_inner
            assign right_w = cell_entry[i+1];
        end

        pqsi_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .cell_valid  (CountWidth'(i) < count_reg),
            .left_ge     (left_ge_w),
            .left_entry  (left_w),
            .right_entry (right_w),
            .ge          (cell_ge[i]),
            .entry       (cell_entry[i])
        );
    end

    // Count update and result formation.
    always_comb begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !m_tready;
        status_next    = status_reg;
        out_entry_next = out_entry_reg;
        occ_next       = occ_reg;
        if (in_fire) begin
            out_valid_next = 1'b1;
            out_entry_next = '0;
            if (s_tuser[0] == CMD_ENQUEUE) begin
                if (is_full) begin
                    status_next = ST_FULL;
                end else begin
                    status_next = ST_ENQUEUED;
                    count_next  = count_reg + 1'b1;
                end
            end else begin
                if (is_empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    status_next    = ST_DEQUEUED;
                    out_entry_next = cell_entry[0];
                    count_next     = count_reg - 1'b1;
                end
            end
            occ_next = OccupancyWidth'(count_next);
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        status_reg    <= status_next;
        out_entry_reg <= out_entry_next;
        occ_reg       <= occ_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {3'b000, occ_reg, out_entry_reg.prio, out_entry_reg.value};

endmodule
